@@ hdl/fmtc_pkg.sv @@
package fmtc_pkg;

  localparam int CpW        = 21;
  localparam int MaxMarkers = 4;
  localparam int MarkCntW   = $clog2(MaxMarkers + 1);

  localparam int NumDigitBlocks = 20;
  localparam int NumHan         = 10;
  localparam int NumPunct       = 33;

  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;

  typedef struct packed {
    logic is_space;
    logic is_marker;
  } cp_class_t;

  localparam logic [CpW-1:0] DigitStarts [NumDigitBlocks] = '{
    21'h0660, 21'h06F0, 21'h07C0, 21'h0966, 21'h09E6, 21'h0A66, 21'h0AE6,
    21'h0B66, 21'h0BE6, 21'h0C66, 21'h0CE6, 21'h0D66, 21'h0DE6, 21'h0E50,
    21'h0ED0, 21'h0F20, 21'h1040, 21'h17E0, 21'h1810, 21'hFF10
  };

  localparam logic [CpW-1:0] HanTen [NumHan] = '{
    21'h4E00, 21'h4E8C, 21'h4E09, 21'h56DB, 21'h4E94, 21'h516D, 21'h4E03,
    21'h516B, 21'h4E5D, 21'h5341
  };

  localparam logic [CpW-1:0] PunctSyms [NumPunct] = '{
    21'h002E, 21'h002C, 21'h005B, 21'h005D, 21'h0028, 21'h0029, 21'h207D,
    21'h207E, 21'h208D, 21'h208E, 21'h3008, 21'h3009, 21'h3010, 21'h3011,
    21'h3014, 21'h3015, 21'hFF08, 21'hFF09, 21'hFF0C, 21'hFF0E, 21'hFF3B,
    21'hFF3D, 21'h002A, 21'h00A7, 21'h00B6, 21'h2020, 21'h2021, 21'h2042,
    21'h204E, 21'h2051, 21'h203B, 21'hFE61, 21'hFF0A
  };

endpackage

@@ hdl/fmtc_classify.sv @@
module fmtc_classify (
  input  logic [fmtc_pkg::CpW-1:0] cp,
  output fmtc_pkg::cp_class_t      cls
);

  function automatic logic space_of(input logic [fmtc_pkg::CpW-1:0] c);
    return c == 21'h0020 || c == 21'h0009 || c == 21'h000D || c == 21'h000A ||
           c == 21'h00A0 || (c >= 21'h2000 && c <= 21'h200B) || c == 21'h202F ||
           c == 21'h205F || c == 21'h3000 || c == 21'hFEFF;
  endfunction

  function automatic logic marker_of(input logic [fmtc_pkg::CpW-1:0] c);
    logic hit;
    hit = (c >= 21'h0030 && c <= 21'h0039) ||
          c == 21'h00B9 || c == 21'h00B2 || c == 21'h00B3 ||
          c == 21'h2070 || (c >= 21'h2074 && c <= 21'h2079) ||
          (c >= 21'h2080 && c <= 21'h2089) ||
          (c >= 21'h2460 && c <= 21'h249B) || c == 21'h24EA ||
          (c >= 21'h2776 && c <= 21'h2793);
    for (int i = 0; i < fmtc_pkg::NumDigitBlocks; i++) begin
      if (c >= fmtc_pkg::DigitStarts[i] &&
          c <= fmtc_pkg::DigitStarts[i] + 21'd9) begin
        hit = 1'b1;
      end
    end
    for (int i = 0; i < fmtc_pkg::NumHan; i++) begin
      if (c == fmtc_pkg::HanTen[i]) begin
        hit = 1'b1;
      end
    end
    for (int i = 0; i < fmtc_pkg::NumPunct; i++) begin
      if (c == fmtc_pkg::PunctSyms[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  always_comb begin
    cls.is_space  = space_of(cp);
    cls.is_marker = marker_of(cp);
  end

endmodule

@@ hdl/footnote_marker_text_classifier.sv @@
// Channel  | Ports                                  | Moves
// ---------+----------------------------------------+------------------------------
// in       | in_valid, in_stall, in_data_byte,      | one text byte per transfer
//          | in_last_byte                           |
// out      | out_valid, out_stall, out_is_marker    | one verdict per text, on last
//
// One byte per cycle sustained unless a waiting verdict holds a last byte;
// a byte sits in the input register, where UTF-8 decode and codepoint
// classification run; the result register takes the verdict as a last byte leaves.
// rst_n (synchronous, low) clears all control state and empties both registers.
// A waiting verdict stalls only a following last byte; other bytes keep flowing.
module footnote_marker_text_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_marker
);

  function automatic logic [1:0] needed_after(input logic [7:0] lead);
    priority if (lead >= 8'hF0) return 2'd3;
    else if (lead >= 8'hE0) return 2'd2;
    else if (lead >= 8'hC0) return 2'd1;
    else return 2'd0;
  endfunction

  logic       s_valid_r, s_valid_nxt;
  logic [7:0] s_byte_r;
  logic       s_last_r;

  logic [7:0] lead_r, lead_nxt;
  logic [5:0] cont0_r, cont0_nxt;
  logic [5:0] cont1_r, cont1_nxt;
  logic [1:0] pend_r, pend_nxt;
  logic [fmtc_pkg::MarkCntW-1:0] mcnt_r, mcnt_nxt;
  logic       sam_r, sam_nxt;
  logic       rej_r, rej_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_mark_r, out_mark_nxt;

  logic       out_free, fire, accept;
  logic [1:0] need, got;
  logic       do_class;
  logic [fmtc_pkg::CpW-1:0] cp;
  fmtc_pkg::cp_class_t cls;
  logic [fmtc_pkg::MarkCntW-1:0] mcnt_c;
  logic       sam_c, rej_c;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s_valid_r && (!s_last_r || out_free);
  assign in_stall = s_valid_r && !fire;
  assign accept   = in_valid && !in_stall;

  assign out_valid     = out_valid_r;
  assign out_is_marker = out_mark_r;

  fmtc_classify u_classify (
    .cp  (cp),
    .cls (cls)
  );

  always_comb begin
    need      = needed_after(lead_r);
    got       = (need >= pend_r) ? need - pend_r : 2'd0;
    if (got > 2'd2) begin
      got = 2'd2;
    end
    lead_nxt  = lead_r;
    cont0_nxt = cont0_r;
    cont1_nxt = cont1_r;
    pend_nxt  = pend_r;
    do_class  = 1'b0;
    cp        = {{(fmtc_pkg::CpW-8){1'b0}}, s_byte_r};
    if (pend_r == fmtc_pkg::PendNone) begin
      if (needed_after(s_byte_r) == 2'd0 || s_last_r) begin
        do_class = 1'b1;
      end else begin
        lead_nxt = s_byte_r;
        pend_nxt = needed_after(s_byte_r);
      end
    end else if (pend_r == fmtc_pkg::PendOne || s_last_r) begin
      do_class = 1'b1;
      pend_nxt = fmtc_pkg::PendNone;
      unique case (got)
        2'd0:    cp = {10'd0, lead_r[4:0], s_byte_r[5:0]};
        2'd1:    cp = {5'd0, lead_r[3:0], cont0_r, s_byte_r[5:0]};
        default: cp = {lead_r[2:0], cont0_r, cont1_r, s_byte_r[5:0]};
      endcase
    end else begin
      if (got[0]) begin
        cont1_nxt = s_byte_r[5:0];
      end else begin
        cont0_nxt = s_byte_r[5:0];
      end
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_comb begin
    mcnt_c = mcnt_r;
    sam_c  = sam_r;
    rej_c  = rej_r;
    if (do_class) begin
      priority if (cls.is_space) begin
        if (mcnt_r != '0) begin
          sam_c = 1'b1;
        end
      end else if (cls.is_marker) begin
        priority if (sam_r) begin
          rej_c = 1'b1;
        end else if (mcnt_r >= fmtc_pkg::MarkCntW'(fmtc_pkg::MaxMarkers)) begin
          rej_c = 1'b1;
        end else begin
          mcnt_c = mcnt_r + fmtc_pkg::MarkCntW'(1);
        end
      end else begin
        rej_c = 1'b1;
      end
    end
  end

  always_comb begin
    s_valid_nxt   = accept ? 1'b1 : (fire ? 1'b0 : s_valid_r);
    mcnt_nxt      = mcnt_r;
    sam_nxt       = sam_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_mark_nxt  = out_mark_r;
    if (fire) begin
      if (s_last_r) begin
        mcnt_nxt      = '0;
        sam_nxt       = 1'b0;
        rej_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
        out_mark_nxt  = !rej_c && (mcnt_c != '0);
      end else begin
        mcnt_nxt = mcnt_c;
        sam_nxt  = sam_c;
        rej_nxt  = rej_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      pend_r      <= fmtc_pkg::PendNone;
      mcnt_r      <= '0;
      sam_r       <= 1'b0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s_valid_r   <= s_valid_nxt;
      pend_r      <= fire ? (s_last_r ? fmtc_pkg::PendNone : pend_nxt) : pend_r;
      mcnt_r      <= mcnt_nxt;
      sam_r       <= sam_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_byte_r <= in_data_byte;
      s_last_r <= in_last_byte;
    end
    if (fire) begin
      lead_r  <= lead_nxt;
      cont0_r <= cont0_nxt;
      cont1_r <= cont1_nxt;
    end
    out_mark_r <= out_mark_nxt;
  end

endmodule

@@ bench/footnote_marker_text_classifier_check.sv @@
`timescale 1ns / 1ps
module footnote_marker_text_classifier_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_is_marker,
  output int         fail_count,
  output int         outstanding
);

  logic [7:0]                    lead_q;
  logic [5:0]                    tail_bits [2];
  logic [1:0]                    pend_q;
  logic [fmtc_pkg::MarkCntW-1:0] marks_q;
  logic                          spaced_q;
  logic                          reject_q;
  logic                          verdict_q [$];
  logic                          want;
  int                            errors = 0;

  function automatic logic [1:0] tail_len(input logic [7:0] b);
    if (b >= 8'hF0) return 2'd3;
    if (b >= 8'hE0) return 2'd2;
    if (b >= 8'hC0) return 2'd1;
    return fmtc_pkg::PendNone;
  endfunction

  function automatic logic space_cp(input logic [fmtc_pkg::CpW-1:0] cp);
    return cp == 21'h20 || cp == 21'h09 || cp == 21'h0D || cp == 21'h0A || cp == 21'h00A0 ||
           (cp >= 21'h2000 && cp <= 21'h200B) || cp == 21'h202F || cp == 21'h205F ||
           cp == 21'h3000 || cp == 21'hFEFF;
  endfunction

  function automatic logic marker_cp(input logic [fmtc_pkg::CpW-1:0] cp);
    if (cp >= 21'h30 && cp <= 21'h39) return 1'b1;
    if (cp == 21'hB9 || cp == 21'hB2 || cp == 21'hB3) return 1'b1;
    if (cp == 21'h2070 || (cp >= 21'h2074 && cp <= 21'h2079)) return 1'b1;
    if (cp >= 21'h2080 && cp <= 21'h2089) return 1'b1;
    if ((cp >= 21'h2460 && cp <= 21'h249B) || cp == 21'h24EA ||
        (cp >= 21'h2776 && cp <= 21'h2793)) return 1'b1;
    for (int i = 0; i < fmtc_pkg::NumDigitBlocks; i++) begin
      if (cp >= fmtc_pkg::DigitStarts[i] && cp <= fmtc_pkg::DigitStarts[i] + 21'd9) return 1'b1;
    end
    for (int i = 0; i < fmtc_pkg::NumHan; i++) begin
      if (cp == fmtc_pkg::HanTen[i]) return 1'b1;
    end
    for (int i = 0; i < fmtc_pkg::NumPunct; i++) begin
      if (cp == fmtc_pkg::PunctSyms[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic clear_text();
    lead_q       = '0;
    tail_bits[0] = '0;
    tail_bits[1] = '0;
    pend_q       = fmtc_pkg::PendNone;
    marks_q      = '0;
    spaced_q     = 1'b0;
    reject_q     = 1'b0;
  endtask

  task automatic take_cp(input logic [fmtc_pkg::CpW-1:0] cp);
    if (space_cp(cp)) begin
      if (marks_q != '0) spaced_q = 1'b1;
    end else if (marker_cp(cp)) begin
      if (spaced_q || marks_q >= fmtc_pkg::MarkCntW'(fmtc_pkg::MaxMarkers)) reject_q = 1'b1;
      else marks_q = marks_q + fmtc_pkg::MarkCntW'(1);
    end else begin
      reject_q = 1'b1;
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    logic [1:0]               need;
    logic [1:0]               got;
    logic [5:0]               k [3];
    logic [fmtc_pkg::CpW-1:0] cp;
    if (pend_q == fmtc_pkg::PendNone) begin
      need = tail_len(b);
      if (need == fmtc_pkg::PendNone || last) begin
        take_cp({13'd0, b});
      end else begin
        lead_q = b;
        pend_q = need;
      end
    end else begin
      need = tail_len(lead_q);
      got  = (need >= pend_q) ? need - pend_q : 2'd0;
      if (got > 2'd2) got = 2'd2;
      if (pend_q == fmtc_pkg::PendOne || last) begin
        k[0] = '0;
        k[1] = '0;
        k[2] = '0;
        if (got != 2'd0) k[0] = tail_bits[0];
        if (got == 2'd2) k[1] = tail_bits[1];
        k[got] = b[5:0];
        case (got)
          2'd0: begin
            cp = {10'd0, lead_q[4:0], k[0]};
          end
          2'd1: begin
            cp = {5'd0, lead_q[3:0], k[0], k[1]};
          end
          default: begin
            cp = {lead_q[2:0], k[0], k[1], k[2]};
          end
        endcase
        take_cp(cp);
        pend_q = fmtc_pkg::PendNone;
      end else begin
        tail_bits[got[0]] = b[5:0];
        pend_q = pend_q - 2'd1;
      end
    end
    if (last) begin
      verdict_q.push_back(!reject_q && marks_q != '0);
      clear_text();
    end
  endtask

  task automatic report(input string what, input logic exp_bit, input logic got_bit);
    errors++;
    if (errors <= 10) begin
      $display("%0t ns: %s: expected is_marker %b, got %b", $time, what, exp_bit, got_bit);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_text();
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          report("verdict with none pending", 1'bx, out_is_marker);
        end else begin
          want = verdict_q.pop_front();
          if (out_is_marker !== want) report("verdict mismatch", want, out_is_marker);
        end
      end
      if (in_valid && !in_stall) take_byte(in_data_byte, in_last_byte);
    end
    fail_count  <= errors;
    outstanding <= verdict_q.size();
  end

endmodule

@@ bench/footnote_marker_text_classifier_test.sv @@
`timescale 1ns / 1ps
module footnote_marker_text_classifier_test;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic       out_is_marker;
  logic       hold_out;
  logic [1:0] phase;
  int         in_idle_pct;
  int         out_idle_pct;
  int         fail_count;
  int         outstanding;
  int         sent;
  int         guard;
  logic [7:0] text_q [$];

  footnote_marker_text_classifier dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_marker(out_is_marker)
  );

  footnote_marker_text_classifier_check verdict_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_marker(out_is_marker),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_400_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= hold_out || ($urandom_range(99) < out_idle_pct);
    end
  end

  // hold off the receiver long enough for a waiting verdict to stall the input
  initial begin
    hold_out = 1'b0;
    wait (phase == 2'd2);
    repeat (30) @(posedge clk);
    hold_out <= 1'b1;
    repeat (400) @(posedge clk);
    hold_out <= 1'b0;
  end

  function automatic logic [20:0] rand_marker();
    logic [20:0] odd [5] = '{21'hB9, 21'hB2, 21'hB3, 21'h2070, 21'h24EA};
    case ($urandom_range(8))
      0: return 21'h30 + 21'($urandom_range(9));
      1: return odd[3'($urandom_range(4))];
      2: return 21'h2080 + 21'($urandom_range(9));
      3: return 21'h2460 + 21'($urandom_range(59));
      4: return 21'h2776 + 21'($urandom_range(29));
      5: return fmtc_pkg::DigitStarts[5'($urandom_range(fmtc_pkg::NumDigitBlocks - 1))] +
                21'($urandom_range(9));
      6: return fmtc_pkg::HanTen[4'($urandom_range(fmtc_pkg::NumHan - 1))];
      7: return fmtc_pkg::PunctSyms[6'($urandom_range(fmtc_pkg::NumPunct - 1))];
      default: return 21'h2074 + 21'($urandom_range(5));
    endcase
  endfunction

  function automatic logic [20:0] rand_space();
    logic [20:0] blanks [9] = '{21'h20, 21'h09, 21'h0D, 21'h0A, 21'hA0, 21'h202F, 21'h205F,
                                21'h3000, 21'hFEFF};
    if ($urandom_range(3) == 0) return 21'h2000 + 21'($urandom_range(11));
    return blanks[4'($urandom_range(8))];
  endfunction

  function automatic logic [20:0] rand_other();
    logic [20:0] near [14] = '{21'h2F, 21'h3A, 21'h2071, 21'h207A, 21'h208A, 21'h249C,
                               21'h2794, 21'h200C, 21'h1FFF, 21'h24E9, 21'h4E01, 21'hFF1A,
                               21'h065F, 21'h066A};
    case ($urandom_range(3))
      0: return 21'h61 + 21'($urandom_range(25));
      1: return near[4'($urandom_range(13))];
      2: return 21'($urandom);
      default: return 21'h80 + 21'($urandom_range(21'h77F));
    endcase
  endfunction

  task automatic put_cp(input logic [20:0] cp, input bit cut);
    int         n;
    int         keep;
    logic [7:0] seq [4];
    if (cp < 21'h80) n = 1;
    else if (cp < 21'h800) n = 2;
    else if (cp < 21'h10000) n = 3;
    else n = 4;
    if (n < 4 && $urandom_range(15) == 0) n = n + 1;
    case (n)
      1: seq[0] = cp[7:0];
      2: seq[0] = {3'b110, cp[10:6]};
      3: seq[0] = {4'b1110, cp[15:12]};
      default: seq[0] = {4'b1111, 1'($urandom), cp[20:18]};
    endcase
    for (int i = 1; i < n; i++) begin
      seq[2'(i)] = {($urandom_range(7) == 0) ? 2'($urandom) : 2'b10,
                    6'(cp >> (6 * (n - 1 - i)))};
    end
    keep = n;
    // drop trailing bytes to cut the sequence short
    if (cut && n > 1) keep = $urandom_range(1, n - 1);
    for (int i = 0; i < keep; i++) text_q.push_back(seq[2'(i)]);
  endtask

  task automatic build_text();
    int kind;
    int marks;
    int r;
    text_q.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom));
    end else begin
      marks = $urandom_range(1, 4);
      r = $urandom_range(99);
      if (r < 8) marks = 0;
      else if (r < 16) marks = $urandom_range(5, 6);
      repeat ($urandom_range(2)) put_cp(rand_space(), 1'b0);
      for (int m = 0; m < marks; m++) begin
        if (m > 0 && $urandom_range(19) == 0) put_cp(rand_space(), 1'b0);
        if ($urandom_range(19) == 0) put_cp(rand_other(), 1'b0);
        else put_cp(rand_marker(), 1'b0);
      end
      repeat ($urandom_range(2)) put_cp(rand_space(), 1'b0);
      if (kind < 22) put_cp($urandom_range(1) ? rand_marker() : rand_other(), 1'b1);
    end
    if (text_q.size() == 0) text_q.push_back(8'h20);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      while ($urandom_range(99) < in_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_data_byte <= text_q[i];
      in_last_byte <= (i == text_q.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    phase        = 2'd0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    text_q = '{8'h31};
    send_text();
    text_q = '{8'h20};
    send_text();
    text_q = '{8'hFF};
    send_text();
    text_q = '{8'h00};
    send_text();
    text_q = '{8'h20, 8'h5B, 8'h31, 8'h5D, 8'h20, 8'h09};
    send_text();
    text_q = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35};
    send_text();
    text_q = '{8'h31, 8'h20, 8'h32};
    send_text();
    text_q = '{8'hC2, 8'hB9};
    send_text();
    text_q = '{8'hE0, 8'hB1};
    send_text();
    text_q = '{8'hF2, 8'h91, 8'hA0};
    send_text();
    text_q = '{8'hE3, 8'h80, 8'h80, 8'h31};
    send_text();

    for (int p = 0; p < 3; p++) begin
      phase        <= 2'(p);
      in_idle_pct   = (p == 0) ? 34 : (p == 1) ? 68 : 0;
      out_idle_pct <= (p == 0) ? 68 : (p == 1) ? 34 : 0;
      sent = 0;
      while (sent < 480) begin
        build_text();
        sent += text_q.size();
        send_text();
      end
    end
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    guard = 0;
    while (outstanding != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
